@@ design/plrt_pkg.sv @@
// ----------------------------------------------------------------------------
// plrt_pkg: shared types and constants of the peer liveness rank table
// Holds the beat formats, the action codes and the front-to-back command.
// ----------------------------------------------------------------------------
package plrt_pkg;

  // table geometry
  localparam int NODE_SLOTS = 255;
  localparam int SLOT_W     = 8;
  localparam int CLK_W      = 63;
  localparam int ENTRY_W    = 2 * CLK_W;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = 1;
  localparam int CNT_W      = 2;

  // configuration register indexes
  localparam logic [7:0] REG_PING_PERIOD = 8'd0;
  localparam logic [7:0] REG_OWN_SLOT    = 8'd1;

  // reset values
  localparam logic [15:0] PING_PERIOD_RST = 16'd1000;

  // action codes
  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_PING   = 2'd1;
  localparam logic [1:0] ACT_SYNC   = 2'd2;
  localparam logic [1:0] ACT_ROUTE  = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [CLK_W-1:0]  peer_clock;
    logic [CLK_W-1:0]  now;
    logic signed [15:0] target;
  } in_beat_t;

  typedef struct packed {
    logic signed [8:0]  my_rank;
    logic [7:0]         alive_count;
    logic               for_me;
    logic signed [63:0] clock_delta;
  } out_beat_t;

  typedef enum logic {
    CMD_UPDATE,
    CMD_ROUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  wr_idx;
    logic [CLK_W-1:0]   wr_clk;
    logic [CLK_W-1:0]   now;
    logic signed [15:0] target;
    logic signed [63:0] delta;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  dividend;
    logic [14:0] divisor;
  } rem_req_t;

endpackage

@@ design/peer_liveness_rank_table_top.sv @@
// ----------------------------------------------------------------------------
// peer_liveness_rank_table_top: peer liveness table with rank and routing
// Tracks peer clocks per slot, expires stale entries, derives own rank and
// decides whether addressed events are meant for this node.
// ----------------------------------------------------------------------------
// An update (peer report, own ping, host sync) writes the slot, then makes one
// table read per slot through the single read port of the 255-entry table
// RAM, then emits the result. A route check emits its result directly, or,
// when a remainder is needed, after the bit-serial remainder unit has run.
// Two input beats queue ahead of the engine, and the result register holds
// one finished beat while the next is worked.
// Registers: index 0 ping_period, index 1 own_slot; cfg_ready is always high.
module peer_liveness_rank_table_top
  import plrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]       ping_period;
  logic [SLOT_W-1:0] own_slot;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ping_period <= PING_PERIOD_RST;
      own_slot    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PING_PERIOD: ping_period <= cfg_data;
        REG_OWN_SLOT:    own_slot    <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  plrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .own_slot  (own_slot),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  plrt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .ping_period (ping_period),
    .own_slot    (own_slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

@@ design/plrt_ram.sv @@
// ----------------------------------------------------------------------------
// plrt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/plrt_rem.sv @@
// ----------------------------------------------------------------------------
// plrt_rem: iterative remainder unit
// Restoring division of an 8-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plrt_rem
  import plrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output logic     done,
  output logic [7:0] rem
);

  logic        busy;
  logic [2:0]  cnt;
  logic [7:0]  quo;
  logic [14:0] part;
  logic [14:0] dsr;
  logic [15:0] shifted;
  logic [15:0] part_next;

  // one restoring step
  always_comb begin
    shifted   = {part, quo[7]};
    part_next = shifted;
    if (shifted >= {1'b0, dsr}) begin
      part_next = shifted - {1'b0, dsr};
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        part <= '0;
      end else if (busy) begin
        part <= part_next[14:0];
        quo  <= {quo[6:0], 1'b0};
        cnt  <= cnt + 3'd1;
        done <= (cnt == 3'd7);
        if (cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rem = part[7:0];

endmodule

@@ design/plrt_front.sv @@
// ----------------------------------------------------------------------------
// plrt_front: input acceptance, classification and command queue
// Turns each input beat into a table update or a route check command.
// ----------------------------------------------------------------------------
module plrt_front
  import plrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  input  logic [SLOT_W-1:0] own_slot,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             cls;
  logic             push;

  // classify the action
  always_comb begin
    cls        = '0;
    cls.now    = in_data.now;
    cls.target = in_data.target;
    unique case (in_data.action)
      ACT_REPORT: begin
        cls.kind   = CMD_UPDATE;
        cls.wr_idx = in_data.slot;
        cls.wr_clk = in_data.peer_clock;
      end
      ACT_PING: begin
        cls.kind   = CMD_UPDATE;
        cls.wr_idx = own_slot;
        cls.wr_clk = in_data.now;
      end
      ACT_SYNC: begin
        cls.kind   = CMD_UPDATE;
        cls.wr_idx = own_slot;
        cls.wr_clk = in_data.now;
        cls.delta  = {1'b0, in_data.peer_clock} - {1'b0, in_data.now};
      end
      default: begin
        cls.kind = CMD_ROUTE;
      end
    endcase
  end

  assign in_stall  = (count == CNT_W'(FIFO_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = fifo[rd_ptr];

  // command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        fifo[wr_ptr] <= cls;
        wr_ptr       <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/plrt_back.sv @@
// ----------------------------------------------------------------------------
// plrt_back: table engine and route check
// Writes one slot, scans the table for liveness and rank, answers route
// checks, and holds the result register.
// ----------------------------------------------------------------------------
module plrt_back
  import plrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [15:0]       ping_period,
  input  logic [SLOT_W-1:0] own_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_ROUTE,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [NODE_SLOTS-1:0] valid;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] chk_idx;
  logic              chk_vld;
  logic [7:0]        live_acc;
  logic [7:0]        ahead_acc;
  logic signed [8:0] rank;
  logic [7:0]        live_count;
  logic              res_for_me;
  logic              div_grp;
  logic              out_load;

  logic              ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CLK_W-1:0]  ent_clk;
  logic [CLK_W-1:0]  ent_time;
  logic [63:0]       expiry;
  logic              ent_live;
  logic              ent_ahead;
  logic [7:0]        live_next;
  logic [7:0]        ahead_next;

  rem_req_t          rem_req;
  logic              rem_done;
  logic [7:0]        rem_val;
  logic [14:0]       grp_div;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign ram_we   = (state == S_WRITE) && (cur.wr_idx < SLOT_W'(NODE_SLOTS));
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  plrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.wr_idx),
    .wdata ({cur.wr_clk, cur.now}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // liveness and rank test of the entry read back
  always_comb begin
    ent_clk    = ram_rdata[ENTRY_W-1:CLK_W];
    ent_time   = ram_rdata[CLK_W-1:0];
    expiry     = {1'b0, ent_time} + {47'd0, ping_period, 1'b0};
    ent_live   = chk_vld && valid[chk_idx] && ({1'b0, cur.now} < expiry);
    ent_ahead  = ent_live && (chk_idx != own_slot) && (ent_clk > ent_time);
    live_next  = live_acc + {7'd0, ent_live};
    ahead_next = ahead_acc + {7'd0, ent_ahead};
  end

  assign grp_div = cur.target[14:0] - 15'd255;

  // route check request to the remainder unit
  always_comb begin
    rem_req = '0;
    if (state == S_ROUTE && !cur.target[15]) begin
      if (cur.target <= 16'sd255) begin
        if (live_count != '0 && cur.target[7:0] >= live_count) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = cur.target[7:0];
          rem_req.divisor  = {7'd0, live_count};
        end
      end else if (!rank[8]) begin
        rem_req.start    = 1'b1;
        rem_req.dividend = rank[7:0];
        rem_req.divisor  = grp_div;
      end
    end
  end

  plrt_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .req  (rem_req),
    .done (rem_done),
    .rem  (rem_val)
  );

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      rank       <= -9'sd1;
      live_count <= 8'd1;
      out_valid  <= 1'b0;
      chk_vld    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= (cmd.kind == CMD_UPDATE) ? S_WRITE : S_ROUTE;
          end
        end
        S_WRITE: begin
          if (ram_we) begin
            valid[cur.wr_idx] <= (cur.wr_clk != '0);
          end
          rd_addr    <= '0;
          chk_vld    <= 1'b0;
          live_acc   <= '0;
          ahead_acc  <= '0;
          res_for_me <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          chk_idx <= rd_addr;
          if (rd_addr < SLOT_W'(NODE_SLOTS)) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (chk_vld) begin
            live_acc  <= live_next;
            ahead_acc <= ahead_next;
            if (valid[chk_idx] && !ent_live) begin
              valid[chk_idx] <= 1'b0;
            end
          end
          // last slot checked: publish count and rank
          if (chk_vld && chk_idx == SLOT_W'(NODE_SLOTS - 1)) begin
            live_count <= live_next;
            rank       <= $signed({1'b0, ahead_next});
            chk_vld    <= 1'b0;
            state      <= S_DONE;
          end else begin
            chk_vld <= (rd_addr < SLOT_W'(NODE_SLOTS));
          end
        end
        S_ROUTE: begin
          if (rem_req.start) begin
            div_grp <= (cur.target > 16'sd255);
            state   <= S_DIV;
          end else begin
            if (cur.target[15]) begin
              res_for_me <= 1'b1;
            end else if (cur.target <= 16'sd255) begin
              res_for_me <= ($signed({1'b0, cur.target[7:0]}) == rank);
            end else begin
              res_for_me <= (grp_div == 15'd1);
            end
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            res_for_me <= div_grp ? (rem_val == '0)
                                  : ($signed({1'b0, rem_val}) == rank);
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data.my_rank     <= rank;
            out_data.alive_count <= live_count;
            out_data.for_me      <= res_for_me;
            out_data.clock_delta <= cur.delta;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
